// ===== rtl/tac8_pkg.sv =====
// Shared types, constants, CORDIC and CRC-8 helpers for the tilt angle block.
// No dependencies.
package tac8_pkg;

   localparam int CordicStagesReq = 16;
   localparam int TableLen = 24;
   localparam int NumStages = (CordicStagesReq > TableLen) ? TableLen : CordicStagesReq;
   localparam int DpWidth = 40;
   localparam int AccWidth = 17;
   localparam logic [15:0] InvGain = 16'd39797;
   localparam logic [7:0] CrcPoly = 8'h8C;
   localparam logic signed [AccWidth-1:0] DegMax = 17'sd90;
   localparam logic signed [AccWidth-1:0] DegMin = -17'sd90;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic [16:0]        abs_x;
      logic [16:0]        abs_y;
      logic [16:0]        abs_z;
   } entry_type;

   typedef struct packed {
      logic signed [DpWidth-1:0]  a;
      logic signed [DpWidth-1:0]  b;
      logic signed [AccWidth-1:0] acc;
   } vec_type;

   function automatic logic signed [AccWidth-1:0] atan_q8(input int idx);
      logic signed [AccWidth-1:0] r;
      r = '0;
      case (idx)
         0: r = 17'sd11520;
         1: r = 17'sd6801;
         2: r = 17'sd3593;
         3: r = 17'sd1824;
         4: r = 17'sd916;
         5: r = 17'sd458;
         6: r = 17'sd229;
         7: r = 17'sd115;
         8: r = 17'sd57;
         9: r = 17'sd29;
         10: r = 17'sd14;
         11: r = 17'sd7;
         12: r = 17'sd4;
         13: r = 17'sd2;
         14: r = 17'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic vec_type cordic_step(input vec_type s, input int idx);
      vec_type r;
      logic signed [DpWidth-1:0] da;
      logic signed [DpWidth-1:0] db;
      r = s;
      da = s.b >>> idx;
      db = s.a >>> idx;
      if (s.b != '0) begin
         if (s.b[DpWidth-1]) begin
            r.a = s.a - da;
            r.b = s.b + db;
            r.acc = s.acc - atan_q8(idx);
         end else begin
            r.a = s.a + da;
            r.b = s.b - db;
            r.acc = s.acc + atan_q8(idx);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CrcPoly;
         else c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ===== rtl/tac8_front.sv =====
// Front end: registers accepted items and forms the axis magnitudes.
// Depends on tac8_pkg.
module tac8_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic signed [15:0]  accel_x,
   input  logic signed [15:0]  accel_y,
   input  logic signed [15:0]  accel_z,
   output logic                push,
   output tac8_pkg::entry_type entry
);
   import tac8_pkg::*;

   logic      valid_ff;
   entry_type entry_ff;
   entry_type entry_in;

   function automatic logic [16:0] mag17(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = {v[15], v};
      return w[16] ? 17'(-w) : 17'(w);
   endfunction

   always_comb begin
      entry_in.axis_x = accel_x;
      entry_in.axis_y = accel_y;
      entry_in.abs_x = mag17(accel_x);
      entry_in.abs_y = mag17(accel_y);
      entry_in.abs_z = mag17(accel_z);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= take;
      if (take) entry_ff <= entry_in;
   end

   assign push = valid_ff;
   assign entry = entry_ff;
endmodule

// ===== rtl/tac8_fifo.sv =====
// Two-entry item queue between front end and CORDIC back end.
// Depends on tac8_pkg.
module tac8_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tac8_pkg::entry_type wdata,
   output logic                pop,
   output tac8_pkg::entry_type rdata,
   output logic                full
);
   import tac8_pkg::*;

   entry_type  mem_ff [0:1];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign pop = (count_ff != 2'd0);
   assign full = (count_ff == 2'd2);
   assign rdata = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/tac8_back.sv =====
// Back end: magnitude CORDIC, gain removal, angle CORDIC, clamp and CRC-8.
// Depends on tac8_pkg.
module tac8_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop,
   input  tac8_pkg::entry_type entry,
   output logic                valid,
   output logic [7:0]          tilt_x,
   output logic [7:0]          tilt_y,
   output logic [7:0]          crc
);
   import tac8_pkg::*;

   localparam int Depth = 2 * NumStages + 6;

   logic               vld_ff [0:Depth-1];
   vec_type            p1_ff [0:1][0:NumStages];
   vec_type            p2_ff [0:1][0:NumStages];
   logic signed [15:0] ax1_ff [0:1][0:NumStages];
   logic signed [15:0] axm_ff [0:1];
   logic [DpWidth-1:0] m_ff [0:1];
   logic [7:0]         ang_ff [0:1];
   logic [7:0]         bx_ff, by_ff, crc1_ff;
   logic [7:0]         ox_ff, oy_ff, oc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Depth; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= pop;
         for (int k = 1; k < Depth; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [16:0]        pmag, qmag;
      logic signed [15:0] axis;
      logic [49:0]        prod;
      logic signed [AccWidth-1:0] acc, deg, mag_deg;
      logic signed [AccWidth-1:0] clamped;

      assign pmag = (ln == 0) ? entry.abs_y : entry.abs_x;
      assign qmag = entry.abs_z;
      assign axis = (ln == 0) ? entry.axis_x : entry.axis_y;
      assign prod = p1_ff[ln][NumStages].a[33:0] * InvGain;
      assign acc = p2_ff[ln][NumStages].acc;
      assign mag_deg = (-acc) >>> 8;
      assign deg = acc[AccWidth-1] ? -mag_deg : (acc >>> 8);
      assign clamped = (deg > DegMax) ? DegMax : ((deg < DegMin) ? DegMin : deg);

      always_ff @(posedge clock) begin
         p1_ff[ln][0].a <= DpWidth'({pmag, 16'h0000});
         p1_ff[ln][0].b <= DpWidth'({qmag, 16'h0000});
         p1_ff[ln][0].acc <= '0;
         ax1_ff[ln][0] <= axis;
         m_ff[ln] <= DpWidth'(prod[49:16]);
         axm_ff[ln] <= ax1_ff[ln][NumStages];
         p2_ff[ln][0].a <= m_ff[ln];
         p2_ff[ln][0].b <= {{(DpWidth-32){axm_ff[ln][15]}}, axm_ff[ln], 16'h0000};
         p2_ff[ln][0].acc <= '0;
         ang_ff[ln] <= clamped[7:0];
      end

      for (genvar st = 0; st < NumStages; st++) begin : g_stage
         always_ff @(posedge clock) begin
            p1_ff[ln][st+1] <= cordic_step(p1_ff[ln][st], st);
            ax1_ff[ln][st+1] <= ax1_ff[ln][st];
            p2_ff[ln][st+1] <= cordic_step(p2_ff[ln][st], st);
         end
      end
   end

   always_ff @(posedge clock) begin
      bx_ff <= ang_ff[0];
      by_ff <= ang_ff[1];
      crc1_ff <= crc8_byte(8'h00, ang_ff[0]);
      ox_ff <= bx_ff;
      oy_ff <= by_ff;
      oc_ff <= crc8_byte(crc1_ff, by_ff);
   end

   assign valid = vld_ff[Depth-1];
   assign tilt_x = ox_ff;
   assign tilt_y = oy_ff;
   assign crc = oc_ff;
endmodule

// ===== rtl/accel_tilt_angle_crc8_top.sv =====
// Tilt angles and CRC-8 from one accelerometer sample; fully pipelined.
// A taken start reaches rsp_valid via the front register, queue and back-end pipeline.
// Throughput: one item per cycle, set by the unrolled CORDIC stage pipeline.
// The result strobe cannot be held off; busy stays low in normal operation.
// Reset clears the valid pipeline and the queue; no clearing pass.
// Depends on tac8_pkg, tac8_front, tac8_fifo, tac8_back.
module accel_tilt_angle_crc8_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   output logic signed [7:0]  rsp_tilt_x_deg,
   output logic signed [7:0]  rsp_tilt_y_deg,
   output logic [7:0]         rsp_frame_crc
);
   import tac8_pkg::*;

   logic      take, push, pop, full;
   entry_type fe_entry, q_entry;
   logic [7:0] tx, ty;

   assign busy = full;
   assign take = start & ~busy;

   tac8_front u_front (
      .clock(clock), .reset(reset), .take(take),
      .accel_x(req_accel_x), .accel_y(req_accel_y), .accel_z(req_accel_z),
      .push(push), .entry(fe_entry)
   );

   tac8_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .wdata(fe_entry),
      .pop(pop), .rdata(q_entry), .full(full)
   );

   tac8_back u_back (
      .clock(clock), .reset(reset), .pop(pop), .entry(q_entry),
      .valid(rsp_valid), .tilt_x(tx), .tilt_y(ty), .crc(rsp_frame_crc)
   );

   assign rsp_tilt_x_deg = signed'(tx);
   assign rsp_tilt_y_deg = signed'(ty);
endmodule
